// ===== hdl/cubic_upwind_advection_unit_assert.svh =====
// Assertion macros shared by the cubic upwind advection RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef CUBIC_UPWIND_ADVECTION_UNIT_ASSERT_SVH
`define CUBIC_UPWIND_ADVECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define CUA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CUA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cua_pkg.sv =====
// Package for the cubic upwind advection unit: widths, constants, beat types.
// No dependencies.
package cua_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 24;
	localparam int STEP_W = 25;
	localparam int IN_W   = 6 * DATA_W;

	localparam logic [STEP_W-1:0] STEP_RESET = 25'd3355443;

	// pipeline split
	localparam int STAGES     = 15;
	localparam int FRONT_LAST = 4;
	localparam int POW_LAST   = 10;

	// internal widths
	localparam int NUM_W = 36;
	localparam int MAG_W = 35;
	localparam int XI_W  = 32;
	localparam int X2_W  = 41;
	localparam int X3_W  = 49;
	localparam int TC_W  = 44;
	localparam int TB_W  = 51;
	localparam int TA_W  = 59;
	localparam int Q_W   = 57;
	localparam int SUM_W = 60;

	localparam logic [FRAC_W-1:0] ROUND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

	// floor(m/3) = hi*DIV3_K + floor((hi+lo)/3), m = hi*2^30 + lo
	localparam logic [28:0] DIV3_K = 29'd357913941;
	localparam logic [31:0] DIV3_R = 32'hAAAAAAAB;

	localparam logic [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] sample_p2;
		logic signed [DATA_W-1:0] sample_p1;
		logic signed [DATA_W-1:0] sample_c;
		logic signed [DATA_W-1:0] sample_m1;
		logic signed [DATA_W-1:0] sample_m2;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] c;
		logic [MAG_W-1:0]         na_m;
		logic [MAG_W-1:0]         nb_m;
		logic                     sa;
		logic                     sb;
		logic                     sc;
	} carry_t;

	typedef struct packed {
		carry_t           k;
		logic [XI_W-1:0]  xi;
		logic [X2_W-1:0]  x2;
		logic [TC_W-1:0]  tcr;
	} front_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] c;
		logic                     sa;
		logic                     sb;
		logic                     sc;
		logic [TA_W-1:0]          tar;
		logic [TB_W-1:0]          tb;
		logic [TC_W-1:0]          tcr;
	} pow_t;

endpackage

// ===== hdl/cubic_upwind_advection_unit.sv =====
// Cubic upwind semi-Lagrangian advection, one grid point per beat.
// Throughput one beat per cycle while m_tready stays high.
// Fifteen-stage pipeline with per-stage ready, so bubbles are filled while the output stalls.
// Reset clears all valid bits and loads step_ratio with 3355443 (about 0.2 in unsigned Q1.24).
// Depends on cua_pkg, cua_pipe_ctrl, cua_front, cua_powers, cua_finish and the assertion macro header.
`include "cubic_upwind_advection_unit_assert.svh"

module cubic_upwind_advection_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cua_pkg::STEP_W-1:0]  cfg_wdata,   // step_ratio
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [cua_pkg::IN_W-1:0]    s_tdata,     // m2, m1, c, p1, p2, velocity
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [cua_pkg::DATA_W-1:0]  m_tdata,     // new_sample
	output logic [0:0]                  m_tuser      // saturated
);
	import cua_pkg::*;

	logic [STEP_W-1:0] step_ratio_q;
	logic [STAGES:1]   ld;
	in_beat_t          beat;
	front_t            fo;
	pow_t              po;
	logic              sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_ratio_q <= cfg_wdata;
		end
	end

	assign beat = in_beat_t'(s_tdata);

	cua_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ld        (ld)
	);

	cua_front u_front (
		.clk        (clk),
		.ld         (ld[FRONT_LAST:1]),
		.beat       (beat),
		.step_ratio (step_ratio_q),
		.fo         (fo)
	);

	cua_powers u_powers (
		.clk (clk),
		.ld  (ld[POW_LAST:FRONT_LAST+1]),
		.fi  (fo),
		.po  (po)
	);

	cua_finish u_finish (
		.clk        (clk),
		.ld         (ld[STAGES:POW_LAST+1]),
		.pi         (po),
		.new_sample (m_tdata),
		.saturated  (sat)
	);

	assign m_tuser = sat;

	`CUA_ASSERT_NOW(a_sat_at_rail, m_tvalid && m_tuser[0], m_tdata == OUT_MAX || m_tdata == OUT_MIN, "saturated flag off the rails")
	`CUA_ASSERT_NOW(a_cfg_idle_ready, cfg_we && !m_tvalid, s_tready, "input blocked while idle")

endmodule

// ===== hdl/cua_pipe_ctrl.sv =====
// Valid bits and per-stage ready chain for the advection pipeline.
// Depends on cua_pkg and the assertion macro header.
`include "cubic_upwind_advection_unit_assert.svh"

module cua_pipe_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [cua_pkg::STAGES:1] ld
);
	import cua_pkg::*;

	localparam int MID = STAGES / 2;

	logic [STAGES:1]   valid_q;
	logic [STAGES+1:1] rdy;
	logic [STAGES:1]   vin;

	assign rdy[STAGES+1] = out_ready;
	assign vin = {valid_q[STAGES-1:1], in_valid};

	genvar k;
	generate
		for (k = 1; k <= STAGES; k++) begin : g_rdy
			assign rdy[k] = !valid_q[k] || rdy[k+1];
		end
	endgenerate

	assign ld = rdy[STAGES:1] & vin;
	assign in_ready = rdy[1];
	assign out_valid = valid_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (rdy[STAGES:1] & vin) | (~rdy[STAGES:1] & valid_q);
		end
	end

	`CUA_ASSERT_NEXT(a_beat_enters, in_valid && in_ready, valid_q[1], "accepted beat lost at stage 1")
	`CUA_ASSERT_NOW(a_ready_chain, out_ready, in_ready, "input blocked with output draining")
	`CUA_ASSERT_NEXT(a_mid_holds, valid_q[MID] && !rdy[MID], valid_q[MID], "stalled stage dropped")
	`CUA_ASSERT_NEXT(a_last_fills, ld[STAGES], out_valid, "last stage load not shown")

endmodule

// ===== hdl/cua_front.sv =====
// Stages 1-4: stencil numerators, displacement xi, xi^2 and the linear term product.
// Depends on cua_pkg.
module cua_front (
	input  logic                         clk,
	input  logic [cua_pkg::FRONT_LAST:1] ld,
	input  cua_pkg::in_beat_t            beat,
	input  logic [cua_pkg::STEP_W-1:0]   step_ratio,
	output cua_pkg::front_t              fo
);
	import cua_pkg::*;

	function automatic logic [MAG_W-1:0] abs_num(input logic signed [NUM_W-1:0] x);
		logic [NUM_W-1:0] t;
		t = x[NUM_W-1] ? (~x + 1'b1) : x;
		return t[MAG_W-1:0];
	endfunction

	logic signed [NUM_W-1:0] e_m2, e_m1, e_c, e_p1, e_p2;
	logic signed [NUM_W-1:0] na_pos, nc_pos, na_neg, nc_neg, nb;
	logic                    v_pos;
	logic [DATA_W-1:0]       v_mag;
	logic [56:0]             pv;

	logic signed [DATA_W-1:0] c_s1;
	logic signed [NUM_W-1:0]  na_s1, nb_s1, nc_s1;
	logic [56:0]              pv_s1;
	logic                     xneg_s1;

	logic [57:0]      pv_r;
	carry_t           k_s2;
	logic [MAG_W-1:0] nc_m_s2;
	logic [XI_W-1:0]  xi_s2;

	carry_t          k_s3;
	logic [XI_W-1:0] xi_s3;
	logic [63:0]     xsq_s3;
	logic [66:0]     tcp_s3;

	logic [64:0] xsq_r;
	logic [67:0] tcp_r;
	front_t      fo_s4;

	always_comb begin
		e_m2 = NUM_W'(beat.sample_m2);
		e_m1 = NUM_W'(beat.sample_m1);
		e_c  = NUM_W'(beat.sample_c);
		e_p1 = NUM_W'(beat.sample_p1);
		e_p2 = NUM_W'(beat.sample_p2);
		na_pos = e_p1 - (e_c + (e_c <<< 1)) + (e_m1 + (e_m1 <<< 1)) - e_m2;
		nc_pos = (e_p1 <<< 1) + (e_c + (e_c <<< 1)) - ((e_m1 <<< 2) + (e_m1 <<< 1)) + e_m2;
		na_neg = e_p2 - (e_p1 + (e_p1 <<< 1)) + (e_c + (e_c <<< 1)) - e_m1;
		nc_neg = ((e_p1 <<< 2) + (e_p1 <<< 1)) - e_p2 - (e_c + (e_c <<< 1)) - (e_m1 <<< 1);
		nb = e_p1 - (e_c <<< 1) + e_m1;
		v_pos = !beat.velocity[DATA_W-1] && (beat.velocity != '0);
		v_mag = beat.velocity[DATA_W-1] ? (~beat.velocity + 1'b1) : beat.velocity;
		pv = v_mag * step_ratio;
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			c_s1    <= beat.sample_c;
			na_s1   <= v_pos ? na_pos : na_neg;
			nc_s1   <= v_pos ? nc_pos : nc_neg;
			nb_s1   <= nb;
			pv_s1   <= pv;
			xneg_s1 <= v_pos;
		end
	end

	assign pv_r = {1'b0, pv_s1} + 58'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			k_s2.c    <= c_s1;
			k_s2.na_m <= abs_num(na_s1);
			k_s2.nb_m <= abs_num(nb_s1);
			k_s2.sa   <= na_s1[NUM_W-1] ^ xneg_s1;
			k_s2.sb   <= nb_s1[NUM_W-1];
			k_s2.sc   <= nc_s1[NUM_W-1] ^ xneg_s1;
			nc_m_s2   <= abs_num(nc_s1);
			xi_s2     <= pv_r[55:24];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			k_s3   <= k_s2;
			xi_s3  <= xi_s2;
			xsq_s3 <= xi_s2 * xi_s2;
			tcp_s3 <= nc_m_s2 * xi_s2;
		end
	end

	assign xsq_r = {1'b0, xsq_s3} + 65'(ROUND_HALF);
	assign tcp_r = {1'b0, tcp_s3} + 68'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			fo_s4.k   <= k_s3;
			fo_s4.xi  <= xi_s3;
			fo_s4.x2  <= xsq_r[64:24];
			fo_s4.tcr <= tcp_r[67:24];
		end
	end

	assign fo = fo_s4;

endmodule

// ===== hdl/cua_powers.sv =====
// Stages 5-10: xi^3, quadratic and cubic term products, split into 32-bit partials.
// Depends on cua_pkg.
module cua_powers (
	input  logic                                          clk,
	input  logic [cua_pkg::POW_LAST:cua_pkg::FRONT_LAST+1] ld,
	input  cua_pkg::front_t                               fi,
	output cua_pkg::pow_t                                 po
);
	import cua_pkg::*;

	carry_t          k_s5, k_s6, k_s7, k_s8, k_s9;
	logic [TC_W-1:0] tcr_s5, tcr_s6, tcr_s7, tcr_s8, tcr_s9;

	logic [63:0] x3lo_s5;
	logic [40:0] x3hi_s5;
	logic [66:0] tblo_s5;
	logic [43:0] tbhi_s5;

	logic [72:0] x3p_s6;
	logic [75:0] tbp_s6;

	logic [73:0]     x3_r;
	logic [76:0]     tbp_r;
	logic [X3_W-1:0] x3_s7;
	logic [50:0]     tbr_s7;

	logic [51:0]     tb_r;
	logic [66:0]     talo_s8;
	logic [51:0]     tahi_s8;
	logic [TB_W-1:0] tb_s8, tb_s9;

	logic [83:0] tap_s9;
	logic [84:0] tap_r;
	pow_t        po_s10;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			k_s5    <= fi.k;
			tcr_s5  <= fi.tcr;
			x3lo_s5 <= fi.x2[31:0] * fi.xi;
			x3hi_s5 <= fi.x2[X2_W-1:32] * fi.xi;
			tblo_s5 <= fi.k.nb_m * fi.x2[31:0];
			tbhi_s5 <= fi.k.nb_m * fi.x2[X2_W-1:32];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			k_s6   <= k_s5;
			tcr_s6 <= tcr_s5;
			x3p_s6 <= 73'(x3lo_s5) + {x3hi_s5, 32'd0};
			tbp_s6 <= 76'(tblo_s5) + {tbhi_s5, 32'd0};
		end
	end

	assign x3_r  = {1'b0, x3p_s6} + 74'(ROUND_HALF);
	assign tbp_r = {1'b0, tbp_s6} + 77'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			k_s7   <= k_s6;
			tcr_s7 <= tcr_s6;
			x3_s7  <= x3_r[72:24];
			tbr_s7 <= tbp_r[74:24];
		end
	end

	// divide by two, ties away from zero, on the magnitude
	assign tb_r = {1'b0, tbr_s7} + 52'd1;

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			k_s8    <= k_s7;
			tcr_s8  <= tcr_s7;
			tb_s8   <= tb_r[51:1];
			talo_s8 <= k_s7.na_m * x3_s7[31:0];
			tahi_s8 <= k_s7.na_m * x3_s7[X3_W-1:32];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			k_s9   <= k_s8;
			tcr_s9 <= tcr_s8;
			tb_s9  <= tb_s8;
			tap_s9 <= 84'(talo_s8) + {tahi_s8, 32'd0};
		end
	end

	assign tap_r = {1'b0, tap_s9} + 85'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			po_s10.c   <= k_s9.c;
			po_s10.sa  <= k_s9.sa;
			po_s10.sb  <= k_s9.sb;
			po_s10.sc  <= k_s9.sc;
			po_s10.tar <= tap_r[82:24];
			po_s10.tb  <= tb_s9;
			po_s10.tcr <= tcr_s9;
		end
	end

	assign po = po_s10;

endmodule

// ===== hdl/cua_finish.sv =====
// Stages 11-15: rounded divide by six of the cubic and linear terms, signed sum, saturation.
// Depends on cua_pkg.
module cua_finish (
	input  logic                                       clk,
	input  logic [cua_pkg::STAGES:cua_pkg::POW_LAST+1] ld,
	input  cua_pkg::pow_t                              pi,
	output logic [cua_pkg::DATA_W-1:0]                 new_sample,
	output logic                                       saturated
);
	import cua_pkg::*;

	typedef struct packed {
		logic [27:0] hi;
		logic [30:0] sum;
	} div_prep_t;

	// (x+3)/6 as ((x+3)>>1)/3, split at bit 30
	function automatic div_prep_t div_prep(input logic [TA_W-1:0] x);
		logic [TA_W:0] n;
		div_prep_t     d;
		n = {1'b0, x} + (TA_W+1)'(3);
		d.hi = n[58:31];
		d.sum = {3'b0, n[58:31]} + {1'b0, n[30:1]};
		return d;
	endfunction

	typedef struct packed {
		logic signed [DATA_W-1:0] c;
		logic                     sa;
		logic                     sb;
		logic                     sc;
		logic [TB_W-1:0]          tb;
	} tail_t;

	tail_t     t_s11, t_s12, t_s13;
	div_prep_t da_s11, dc_s11;

	logic [61:0] psa, psc;
	logic [56:0] paa_s12, pac_s12;
	logic [29:0] psa_s12, psc_s12;

	logic [Q_W-1:0] ta_s13, tc_s13;

	logic signed [SUM_W-1:0] e_c, e_ta, e_tb, e_tc;
	logic signed [SUM_W-1:0] sum1_s14, sum2_s14;

	logic signed [SUM_W-1:0] tot;
	logic signed [SUM_W-1:0] sat_hi, sat_lo;
	logic [DATA_W-1:0]       res_s15;
	logic                    sat_s15;

	always_ff @(posedge clk) begin
		if (ld[11]) begin
			t_s11.c  <= pi.c;
			t_s11.sa <= pi.sa;
			t_s11.sb <= pi.sb;
			t_s11.sc <= pi.sc;
			t_s11.tb <= pi.tb;
			da_s11   <= div_prep(pi.tar);
			dc_s11   <= div_prep(TA_W'(pi.tcr));
		end
	end

	assign psa = da_s11.sum * DIV3_R;
	assign psc = dc_s11.sum * DIV3_R;

	always_ff @(posedge clk) begin
		if (ld[12]) begin
			t_s12   <= t_s11;
			paa_s12 <= da_s11.hi * DIV3_K;
			pac_s12 <= dc_s11.hi * DIV3_K;
			psa_s12 <= psa[61:32];
			psc_s12 <= psc[61:32];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[13]) begin
			t_s13  <= t_s12;
			ta_s13 <= paa_s12 + Q_W'(psa_s12 >> 1);
			tc_s13 <= pac_s12 + Q_W'(psc_s12 >> 1);
		end
	end

	always_comb begin
		e_c  = SUM_W'(t_s13.c);
		e_ta = SUM_W'(ta_s13);
		e_tb = SUM_W'(t_s13.tb);
		e_tc = SUM_W'(tc_s13);
	end

	always_ff @(posedge clk) begin
		if (ld[14]) begin
			sum1_s14 <= e_c + (t_s13.sb ? -e_tb : e_tb);
			sum2_s14 <= (t_s13.sa ? -e_ta : e_ta) + (t_s13.sc ? -e_tc : e_tc);
		end
	end

	always_comb begin
		sat_hi = SUM_W'(signed'(OUT_MAX));
		sat_lo = SUM_W'(signed'(OUT_MIN));
		tot = sum1_s14 + sum2_s14;
	end

	always_ff @(posedge clk) begin
		if (ld[15]) begin
			if (tot > sat_hi) begin
				res_s15 <= OUT_MAX;
				sat_s15 <= 1'b1;
			end else if (tot < sat_lo) begin
				res_s15 <= OUT_MIN;
				sat_s15 <= 1'b1;
			end else begin
				res_s15 <= tot[DATA_W-1:0];
				sat_s15 <= 1'b0;
			end
		end
	end

	assign new_sample = res_s15;
	assign saturated = sat_s15;

endmodule

// ===== sim/cubic_upwind_advection_unit_tb.sv =====
// Self-checking testbench for cubic_upwind_advection_unit: directed table, then random beats
// under several step_ratio settings, with random stalls on both streams.
// Depends on cua_pkg and the RTL of the unit; each result is checked against a local predictor or a table value.
module cubic_upwind_advection_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cua_pkg::*;

	localparam logic [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ONE  = 32'h0100_0000;
	localparam logic [DATA_W-1:0] NONE = 32'hFF00_0000;
	localparam logic [STEP_W-1:0] STEP_FULL = 25'd16777216;
	localparam longint TERM_CAP = longint'(1) << 60;
	localparam int IDLE_PCT = 33;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_BEATS = 200;
	localparam int N_DIR = 19;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              sat;
	} point_t;

	typedef struct packed {
		logic              load;
		logic [STEP_W-1:0] ratio;
		logic [DATA_W-1:0] m2, m1, c, p1, p2, vel;
		logic              known;
		logic [DATA_W-1:0] want_val;
		logic              want_sat;
	} stim_row_t;

	// known rows: zero velocity, zero step or a constant field leave the centre unchanged
	localparam stim_row_t DIR_ROWS [0:N_DIR-1] = '{
		'{1'b0, 25'd0, '0, '0, '0, '0, '0, '0, 1'b1, '0, 1'b0},
		'{1'b0, 25'd0, MINV, MINV, MAXV, MINV, MINV, '0, 1'b1, MAXV, 1'b0},
		'{1'b0, 25'd0, MAXV, MAXV, MINV, MAXV, MAXV, '0, 1'b1, MINV, 1'b0},
		'{1'b0, 25'd0, 32'hFE00_0000, NONE, '0, ONE, 32'h0200_0000, ONE, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, 32'hFE00_0000, NONE, '0, ONE, 32'h0200_0000, NONE, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, 32'h0400_0000, ONE, '0, ONE, 32'h0400_0000, 32'd1, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, 32'h0400_0000, ONE, '0, ONE, 32'h0400_0000, 32'hFFFF_FFFF,
			1'b0, '0, 1'b0},
		'{1'b1, 25'd0, MAXV, MINV, 32'h1234_5678, MAXV, MINV, MAXV,
			1'b1, 32'h1234_5678, 1'b0},
		'{1'b0, 25'd0, MAXV, MINV, 32'h1234_5678, MAXV, MINV, MINV,
			1'b1, 32'h1234_5678, 1'b0},
		'{1'b1, STEP_FULL, MINV, MAXV, MINV, MAXV, MINV, MAXV, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, MINV, MAXV, MINV, MAXV, MINV, MINV, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
			32'h1234_5678, ONE, 1'b1, 32'h1234_5678, 1'b0},
		'{1'b0, 25'd0, 32'hF800_0000, NONE, '0, ONE, 32'h0800_0000, 32'h0080_0000,
			1'b0, '0, 1'b0},
		'{1'b0, 25'd0, MAXV, MINV, MAXV, MINV, MAXV, 32'h4000_0000, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, MAXV, MINV, MAXV, MINV, MAXV, 32'hC000_0000, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1, MAXV, 1'b0},
		'{1'b0, 25'd0, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1, MINV, 1'b0},
		'{1'b1, STEP_RESET, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0, 1'b0},
		'{1'b0, 25'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [STEP_W-1:0] cfg_wdata = STEP_RESET;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [0:0]        m_tuser;

	point_t            pending_points [$];
	logic [STEP_W-1:0] ratio_now = STEP_RESET;
	bit                steady = 1'b0;
	int                errors = 0;
	int                results_seen = 0;

	cubic_upwind_advection_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// a*b in Q.FRAC_W, rounded half away from zero, magnitude capped at 2^60
	function automatic longint qmul_round(input longint a, input longint b, inout bit clipped);
		logic [63:0]  ua, ub;
		logic [127:0] r;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		r = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
		if (r > 128'(TERM_CAP)) begin
			clipped = 1'b1;
			r = 128'(TERM_CAP);
		end
		return ((a < 0) != (b < 0)) ? -$signed(r[63:0]) : $signed(r[63:0]);
	endfunction

	function automatic longint div_round(input longint x, input longint d);
		longint q;
		q = (((x < 0) ? -x : x) + d / 2) / d;
		return (x < 0) ? -q : q;
	endfunction

	function automatic point_t advect_point(input in_beat_t b, input logic [STEP_W-1:0] ratio);
		longint m2, m1, c, p1, p2, v, na, nb, nc, xi, xi2, xi3, sum;
		bit     clipped;
		point_t r;
		m2 = longint'(b.sample_m2);
		m1 = longint'(b.sample_m1);
		c  = longint'(b.sample_c);
		p1 = longint'(b.sample_p1);
		p2 = longint'(b.sample_p2);
		v  = longint'(b.velocity);
		clipped = 1'b0;
		if (v > 0) begin
			na = p1 - 3 * c + 3 * m1 - m2;
			nc = 2 * p1 + 3 * c - 6 * m1 + m2;
		end else begin
			na = p2 - 3 * p1 + 3 * c - m1;
			nc = -p2 + 6 * p1 - 3 * c - 2 * m1;
		end
		nb = p1 - 2 * c + m1;
		xi  = -qmul_round(v, longint'(ratio), clipped);
		xi2 = qmul_round(xi, xi, clipped);
		xi3 = qmul_round(xi2, xi, clipped);
		sum = c + div_round(qmul_round(na, xi3, clipped), 6)
			+ div_round(qmul_round(nb, xi2, clipped), 2)
			+ div_round(qmul_round(nc, xi, clipped), 6);
		if (sum > longint'(OUT_MAX)) begin
			sum = longint'(OUT_MAX);
			clipped = 1'b1;
		end
		if (sum < longint'($signed(OUT_MIN))) begin
			sum = longint'($signed(OUT_MIN));
			clipped = 1'b1;
		end
		r.value = sum[DATA_W-1:0];
		r.sat = clipped;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_extreme();
		case ($urandom_range(5))
			0: begin
				return MAXV;
			end
			1: begin
				return MINV;
			end
			2: begin
				return '0;
			end
			3: begin
				return ONE;
			end
			4: begin
				return NONE;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] near(input logic [DATA_W-1:0] base);
		return base + ($urandom & 32'h003F_FFFF) - 32'h0020_0000;
	endfunction

	function automatic in_beat_t rand_point();
		in_beat_t          b;
		logic [DATA_W-1:0] base;
		int                kind;
		kind = $urandom_range(99);
		b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (kind < 50) begin
			// smooth field, moderate velocity
			base = $urandom;
			b.sample_m2 = near(base);
			b.sample_m1 = near(base);
			b.sample_c  = near(base);
			b.sample_p1 = near(base);
			b.sample_p2 = near(base);
			b.velocity = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
		end else if (kind < 70) begin
			b.sample_m2 = pick_extreme();
			b.sample_m1 = pick_extreme();
			b.sample_c  = pick_extreme();
			b.sample_p1 = pick_extreme();
			b.sample_p2 = pick_extreme();
			b.velocity  = pick_extreme();
		end else if (kind < 80) begin
			b.velocity = $urandom_range(0, 2) - 1;
		end
		return b;
	endfunction

	task automatic push_point(input in_beat_t b, input point_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_points = {pending_points, want};
	endtask

	task automatic load_step_ratio(input logic [STEP_W-1:0] ratio);
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ratio;
		@(posedge clk);
		cfg_we <= 1'b0;
		ratio_now = ratio;
	endtask

	initial begin : result_side
		point_t want;
		int     hold_left;
		bit     hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				results_seen++;
				if (pending_points.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected beat: new_sample %h saturated %b",
							m_tdata, m_tuser[0]);
					end
				end else begin
					want = pending_points.pop_front();
					if (m_tdata !== want.value || m_tuser[0] !== want.sat) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at beat %0d: new_sample exp %h got %h, saturated exp %b got %b",
								results_seen, want.value, m_tdata, want.sat, m_tuser[0]);
						end
					end
				end
			end
			// one long hold-off so the pipeline fills and backs up the input
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 300) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		stim_row_t         row;
		in_beat_t          b;
		point_t            want;
		logic [STEP_W-1:0] ratios [0:5];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.load) begin
				load_step_ratio(row.ratio);
			end
			b.sample_m2 = row.m2;
			b.sample_m1 = row.m1;
			b.sample_c  = row.c;
			b.sample_p1 = row.p1;
			b.sample_p2 = row.p2;
			b.velocity  = row.vel;
			if (row.known) begin
				want.value = row.want_val;
				want.sat = row.want_sat;
			end else begin
				want = advect_point(b, ratio_now);
			end
			push_point(b, want);
		end

		ratios[0] = STEP_W'($urandom_range(0, STEP_FULL));
		ratios[1] = STEP_FULL;
		ratios[2] = '0;
		ratios[3] = STEP_W'($urandom_range(0, STEP_FULL));
		ratios[4] = STEP_W'($urandom_range(0, 25'h000F_FFFF));
		ratios[5] = STEP_RESET;
		for (int p = 0; p < 6; p++) begin
			load_step_ratio(ratios[p]);
			steady = (p == 3);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				b = rand_point();
				push_point(b, advect_point(b, ratio_now));
			end
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		for (int n = 0; n < 50000 && pending_points.size() != 0; n++) @(posedge clk);
		repeat (2 * STAGES) @(posedge clk);
		if (pending_points.size() != 0) begin
			$display("%0d expected beats never arrived", pending_points.size());
		end
		if (errors == 0 && pending_points.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#3ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cua_pkg.sv
hdl/cua_pipe_ctrl.sv
hdl/cua_front.sv
hdl/cua_powers.sv
hdl/cua_finish.sv
hdl/cubic_upwind_advection_unit.sv
sim/cubic_upwind_advection_unit_tb.sv
